>>> rtl/d2q_pkg.sv
// d2q_pkg: shared constants for the dcm to quaternion core
// no dependencies
`timescale 1ns / 1ps
package d2q_pkg;
  localparam int FRAC_BITS_DEF = 14;
  localparam int EL_W = 16;
  localparam logic [1:0] PIV_E11 = 2'd0;
  localparam logic [1:0] PIV_E22 = 2'd1;
  localparam logic [1:0] PIV_E33 = 2'd2;
  localparam logic [1:0] PIV_TRC = 2'd3;
endpackage

>>> rtl/dcm_to_quaternion_core.sv
// dcm_to_quaternion_core: matrix to quaternion, pivot selection, square root
// chain of cells, divider chain of cells, rounding and saturation
// throughput: one item per cycle; the whole pipeline advances when not stalled
// reset: rst clears the valid bits of every stage; payload is not reset
`timescale 1ns / 1ps
module dcm_to_quaternion_core import d2q_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  logic signed [15:0] m11, m12, m13, m21, m22, m23, m31, m32, m33,
  output logic out_valid,
  input  logic out_stall,
  output logic signed [15:0] qw, qx, qy, qz,
  output logic [1:0] pivot,
  output logic degenerate
);
  // radicand up to 2^F + 2^18, shifted by F-2
  localparam int RADW = (FRAC_BITS > 18 ? FRAC_BITS : 18) + 3;
  localparam int RW0  = RADW + FRAC_BITS - 2;
  localparam int RW   = RW0 + (RW0 % 2);
  localparam int NST  = RW / 2;
  localparam int QW   = NST;                 // root width
  localparam int TW   = 18;                  // term magnitude width
  localparam int NW   = TW + FRAC_BITS + 1;  // numerator width
  localparam int DW   = QW + 2;
  localparam int NDIV = NW;
  // sideband: 3 signed terms, pivot, degenerate
  localparam int SW   = 3 * TW + 3;

  logic adv;
  assign adv = !(out_valid && out_stall);
  assign in_stall = !adv;

  // stage 0: sums and pivot
  logic signed [17:0] s12, s13, s23, d32, d13, d21, tr, mx;
  logic [1:0] pv_c;
  logic signed [17:0] mx_c;
  logic signed [17:0] a11, a22, a33;
  always_comb begin
    a11 = 18'(m11); a22 = 18'(m22); a33 = 18'(m33);
    mx_c = a11; pv_c = PIV_E11;
    if (a22 > mx_c) begin mx_c = a22; pv_c = PIV_E22; end
    if (a33 > mx_c) begin mx_c = a33; pv_c = PIV_E33; end
    if (a11 + a22 + a33 > mx_c) begin mx_c = a11 + a22 + a33; pv_c = PIV_TRC; end
  end
  logic [1:0] pv0;
  always_ff @(posedge clk) begin
    if (adv) begin
      s12 <= 18'(m12) + 18'(m21);
      s13 <= 18'(m13) + 18'(m31);
      s23 <= 18'(m23) + 18'(m32);
      d32 <= 18'(m32) - 18'(m23);
      d13 <= 18'(m13) - 18'(m31);
      d21 <= 18'(m21) - 18'(m12);
      tr  <= a11 + a22 + a33;
      mx  <= mx_c;
      pv0 <= pv_c;
    end
  end

  // stage 1: radicand and term selection
  logic signed [RADW:0] rad_c;
  logic [2:0][TW-1:0] trm_c;
  assign rad_c = (RADW+1)'(1) <<< FRAC_BITS;
  logic signed [RADW:0] rsum;
  assign rsum = rad_c - (RADW+1)'(tr) + ((RADW+1)'(mx) <<< 1);
  always_comb begin
    case (pv0)
      PIV_E11: trm_c = {d32, s13, s12};
      PIV_E22: trm_c = {d13, s23, s12};
      PIV_E33: trm_c = {d21, s23, s13};
      default: trm_c = {d21, d13, d32};
    endcase
  end
  logic [SW-1:0] side1;
  logic [RW-1:0] rem1;
  always_ff @(posedge clk) begin
    if (adv) begin
      side1 <= {trm_c, pv0, (rsum <= 0)};
      rem1  <= (rsum <= 0) ? '0 : RW'(unsigned'(rsum)) << (FRAC_BITS - 2);
    end
  end

  // square root chain
  logic [RW-1:0] srem [NST+1];
  logic [RW-1:0] sres [NST+1];
  logic [SW-1:0] sside [NST+1];
  assign srem[0] = rem1;
  assign sres[0] = '0;
  assign sside[0] = side1;
  for (genvar g = 0; g < NST; g++) begin : g_sq
    d2q_sqrt_cell #(.RW(RW), .SW(SW), .BITPOS(NST-1-g)) u_cell (
      .clk(clk), .en(adv), .rem_in(srem[g]), .res_in(sres[g]), .side_in(sside[g]),
      .rem_out(srem[g+1]), .res_out(sres[g+1]), .side_out(sside[g+1])
    );
  end

  // prepare divider: mag<<F + 2*qmax over 4*qmax
  logic [QW-1:0] qmax;
  assign qmax = QW'(sres[NST]);
  logic [2:0][NW-1:0] num_c;
  logic [2:0] sgn_c;
  logic [2:0][TW-1:0] tv;
  assign tv = sside[NST][SW-1:3];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sgn_c[i] = tv[i][TW-1];
      num_c[i] = (NW'(sgn_c[i] ? TW'(-tv[i]) : tv[i]) << FRAC_BITS)
                 + (NW'(qmax) << 1);
    end
  end
  localparam int SD = QW + 6;
  logic [2:0][NW-1:0] dnum [NDIV+1];
  logic [2:0][NW-1:0] dquo [NDIV+1];
  logic [SD-1:0] dside [NDIV+1];
  logic [DW-1:0] dden [NDIV+1];
  assign dnum[0] = num_c;
  assign dquo[0] = '0;
  assign dden[0] = DW'(qmax) << 2;
  assign dside[0] = {qmax, sgn_c, sside[NST][2:1],
                     sside[NST][0] || (qmax == '0)};
  for (genvar g = 0; g < NDIV; g++) begin : g_dv
    d2q_div_cell #(.NW(NW), .DW(DW), .SW(SD), .BITPOS(NDIV-1-g)) u_cell (
      .clk(clk), .en(adv), .den(dden[g]), .num_in(dnum[g]), .quo_in(dquo[g]),
      .side_in(dside[g]), .den_pass_in(dden[g]),
      .num_out(dnum[g+1]), .quo_out(dquo[g+1]), .side_out(dside[g+1]),
      .den_pass_out(dden[g+1])
    );
  end

  // saturate and assemble
  logic [SD-1:0] fs;
  assign fs = dside[NDIV];
  logic [2:0][15:0] part;
  logic [15:0] qm16;
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (dquo[NDIV][i] > NW'(32767))
        part[i] = fs[3+i] ? 16'h8001 + 16'(!(dquo[NDIV][i] > NW'(32767))) - 16'd0
                          : 16'h7FFF;
      else
        part[i] = fs[3+i] ? 16'(-dquo[NDIV][i]) : 16'(dquo[NDIV][i]);
      if (fs[3+i] && dquo[NDIV][i] >= NW'(32768)) part[i] = 16'h8000;
    end
    qm16 = (fs[SD-1:6] > QW'(32767)) ? 16'h7FFF : 16'(fs[SD-1:6]);
  end
  logic [15:0] ow, ox, oy, oz;
  always_comb begin
    case (fs[2:1])
      PIV_E11: begin ox = qm16; oy = part[0]; oz = part[1]; ow = part[2]; end
      PIV_E22: begin ox = part[0]; oy = qm16; oz = part[1]; ow = part[2]; end
      PIV_E33: begin ox = part[0]; oy = part[1]; oz = qm16; ow = part[2]; end
      default: begin ox = part[0]; oy = part[1]; oz = part[2]; ow = qm16; end
    endcase
  end

  // valid chain
  localparam int LAT = 2 + NST + NDIV;
  logic [LAT-1:0] vld;
  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else if (adv) vld <= {vld[LAT-2:0], in_valid};
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (adv) out_valid <= vld[LAT-1];
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      degenerate <= fs[0];
      pivot <= fs[2:1];
      qw <= fs[0] ? '0 : ow;
      qx <= fs[0] ? '0 : ox;
      qy <= fs[0] ? '0 : oy;
      qz <= fs[0] ? '0 : oz;
    end
  end
endmodule

>>> rtl/d2q_sqrt_cell.sv
// d2q_sqrt_cell: one stage of the restoring square root chain
// depends on d2q_pkg; carries the item sideband along with the root state
`timescale 1ns / 1ps
module d2q_sqrt_cell import d2q_pkg::*; #(
  parameter int RW = 48,
  parameter int SW = 160,
  parameter int BITPOS = 0
) (
  input  logic          clk,
  input  logic          en,
  input  logic [RW-1:0] rem_in,
  input  logic [RW-1:0] res_in,
  input  logic [SW-1:0] side_in,
  output logic [RW-1:0] rem_out,
  output logic [RW-1:0] res_out,
  output logic [SW-1:0] side_out
);
  localparam logic [RW-1:0] BIT = RW'(1) << (2 * BITPOS);
  logic [RW-1:0] trial;
  logic [RW-1:0] rem_next, res_next;

  // one root digit per cell
  always_comb begin
    trial = res_in + BIT;
    if (rem_in >= trial) begin
      rem_next = rem_in - trial;
      res_next = (res_in >> 1) + BIT;
    end else begin
      rem_next = rem_in;
      res_next = res_in >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_out  <= rem_next;
      res_out  <= res_next;
      side_out <= side_in;
    end
  end
endmodule

>>> rtl/d2q_div_cell.sv
// d2q_div_cell: one stage of a restoring divider lane set
// depends on d2q_pkg; three numerators share one denominator
`timescale 1ns / 1ps
module d2q_div_cell import d2q_pkg::*; #(
  parameter int NW = 48,
  parameter int DW = 32,
  parameter int SW = 32,
  parameter int BITPOS = 0
) (
  input  logic                clk,
  input  logic                en,
  input  logic [DW-1:0]       den,
  input  logic [2:0][NW-1:0]  num_in,
  input  logic [2:0][NW-1:0]  quo_in,
  input  logic [SW-1:0]       side_in,
  input  logic [DW-1:0]       den_pass_in,
  output logic [2:0][NW-1:0]  num_out,
  output logic [2:0][NW-1:0]  quo_out,
  output logic [SW-1:0]       side_out,
  output logic [DW-1:0]       den_pass_out
);
  localparam int WW = NW + DW;
  logic [2:0][NW-1:0] num_next, quo_next;
  logic [WW-1:0] sh;

  // one quotient bit per lane
  always_comb begin
    sh = '0;
    for (int i = 0; i < 3; i++) begin
      sh = WW'(den) << BITPOS;
      num_next[i] = num_in[i];
      quo_next[i] = quo_in[i];
      if (WW'(num_in[i]) >= sh) begin
        num_next[i] = NW'(WW'(num_in[i]) - sh);
        quo_next[i][BITPOS] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      num_out      <= num_next;
      quo_out      <= quo_next;
      side_out     <= side_in;
      den_pass_out <= den_pass_in;
    end
  end
endmodule

>>> tb/sv/dcm_to_quaternion_core_tb.sv
// dcm_to_quaternion_core_tb: self-checking bench for the matrix to quaternion core
// depends on d2q_pkg and dcm_to_quaternion_core
`timescale 1ns / 1ps
module dcm_to_quaternion_core_tb;
  import d2q_pkg::*;

  localparam int FB = FRAC_BITS_DEF;
  localparam int LATENCY = 3 + ((FB > 18 ? FB : 18) + FB + 2) / 2 + FB + 19;

  typedef struct packed {
    logic signed [15:0] e11, e12, e13, e21, e22, e23, e31, e32, e33;
  } dcm_t;

  typedef struct packed {
    logic signed [15:0] w, x, y, z;
    logic [1:0] piv;
    logic degen;
  } quat_t;

  logic clk, rst;
  logic in_valid, in_stall, out_valid, out_stall;
  logic signed [15:0] m11, m12, m13, m21, m22, m23, m31, m32, m33;
  logic signed [15:0] qw, qx, qy, qz;
  logic [1:0] pivot;
  logic degenerate;

  dcm_t pending_dcms[$];
  quat_t expected_quats[$];
  int errors = 0;
  int send_idle_pct = 19;
  int recv_idle_pct = 82;
  int hold_cycles = 0;
  bit stim_done = 0;

  dcm_to_quaternion_core #(.FRAC_BITS(FB)) dut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .m11(m11), .m12(m12), .m13(m13), .m21(m21), .m22(m22), .m23(m23),
    .m31(m31), .m32(m32), .m33(m33), .out_valid(out_valid), .out_stall(out_stall),
    .qw(qw), .qx(qx), .qy(qy), .qz(qz), .pivot(pivot), .degenerate(degenerate)
  );

  // clock and reset
  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  initial begin
    rst = 1;
    repeat (3) @(posedge clk);
    rst <= 0;
  end

  // integer square root, truncated
  function automatic longint unsigned isqrt(longint unsigned v);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic logic signed [15:0] clip16(longint v);
    if (v > 32767) return 16'sd32767;
    if (v < -32768) return -16'sd32768;
    return v[15:0];
  endfunction

  // term / (4*qmax) in Q.F, rounded half away from zero
  function automatic logic signed [15:0] scaled_part(longint term, longint unsigned qm);
    longint unsigned mag, q;
    longint r;
    mag = (term < 0) ? -term : term;
    q = ((mag << FB) + qm * 2) / (qm * 4);
    r = (q > 64'h7FFFFFFF) ? 64'h7FFFFFFF : q;
    return clip16(term < 0 ? -r : r);
  endfunction

  function automatic quat_t dcm_to_quat(dcm_t m);
    quat_t q;
    longint tr, mx, r;
    longint unsigned qm;
    logic signed [15:0] qpiv;
    q = '0;
    tr = longint'(m.e11) + m.e22 + m.e33;
    mx = m.e11;
    q.piv = PIV_E11;
    if (m.e22 > mx) begin mx = m.e22; q.piv = PIV_E22; end
    if (m.e33 > mx) begin mx = m.e33; q.piv = PIV_E33; end
    if (tr > mx) begin mx = tr; q.piv = PIV_TRC; end
    r = (longint'(1) << FB) - tr + 2 * mx;
    if (r <= 0) begin
      q.degen = 1;
      return q;
    end
    qm = isqrt(longint'(r) << (FB - 2));
    if (qm == 0) begin
      q.degen = 1;
      return q;
    end
    qpiv = (qm > 32767) ? 16'sd32767 : qm[15:0];
    case (q.piv)
      PIV_E11: begin
        q.x = qpiv;
        q.y = scaled_part(longint'(m.e12) + m.e21, qm);
        q.z = scaled_part(longint'(m.e13) + m.e31, qm);
        q.w = scaled_part(longint'(m.e32) - m.e23, qm);
      end
      PIV_E22: begin
        q.x = scaled_part(longint'(m.e12) + m.e21, qm);
        q.y = qpiv;
        q.z = scaled_part(longint'(m.e23) + m.e32, qm);
        q.w = scaled_part(longint'(m.e13) - m.e31, qm);
      end
      PIV_E33: begin
        q.x = scaled_part(longint'(m.e13) + m.e31, qm);
        q.y = scaled_part(longint'(m.e23) + m.e32, qm);
        q.z = qpiv;
        q.w = scaled_part(longint'(m.e21) - m.e12, qm);
      end
      default: begin
        q.x = scaled_part(longint'(m.e32) - m.e23, qm);
        q.y = scaled_part(longint'(m.e13) - m.e31, qm);
        q.z = scaled_part(longint'(m.e21) - m.e12, qm);
        q.w = qpiv;
      end
    endcase
    return q;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // random element: mostly near unit range, sometimes full range or extremes
  function automatic logic signed [15:0] rand_elem();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 5) return $signed(16'($urandom_range(0, 32768))) - 16'sd16384;
    if (sel < 8) return 16'($urandom);
    case ($urandom_range(0, 3))
      0: return 16'sd32767;
      1: return -16'sd32768;
      2: return 16'sd16384;
      default: return 16'sd0;
    endcase
  endfunction

  // rotation-like matrix: signed permutation with perturbation
  function automatic dcm_t rand_rotation();
    dcm_t m;
    logic signed [15:0] el[9];
    int perm[3];
    int t;
    perm = '{0, 1, 2};
    for (int i = 2; i > 0; i--) begin
      t = $urandom_range(0, i);
      {perm[i], perm[t]} = {perm[t], perm[i]};
    end
    for (int i = 0; i < 9; i++)
      el[i] = $signed(16'($urandom_range(0, 4000))) - 16'sd2000;
    for (int i = 0; i < 3; i++)
      el[i * 3 + perm[i]] = ($urandom_range(0, 1) ? 16'sd16384 : -16'sd16384)
                            + $signed(16'($urandom_range(0, 2000))) - 16'sd1000;
    m = {el[0], el[1], el[2], el[3], el[4], el[5], el[6], el[7], el[8]};
    return m;
  endfunction

  function automatic dcm_t diag(int a, int b, int c);
    dcm_t m;
    m = '0;
    m.e11 = 16'(a); m.e22 = 16'(b); m.e33 = 16'(c);
    return m;
  endfunction

  // stimulus queue
  initial begin
    dcm_t m;
    // identity, each axis half turn, ties, degenerate and extremes
    pending_dcms.push_back(diag(16384, 16384, 16384));
    pending_dcms.push_back(diag(16384, -16384, -16384));
    pending_dcms.push_back(diag(-16384, 16384, -16384));
    pending_dcms.push_back(diag(-16384, -16384, 16384));
    pending_dcms.push_back(diag(0, 0, 0));
    pending_dcms.push_back(diag(5000, 5000, -9000));
    pending_dcms.push_back(diag(-3000, 7000, 7000));
    pending_dcms.push_back(diag(-32768, -32768, -32768));
    pending_dcms.push_back(diag(32767, 32767, 32767));
    pending_dcms.push_back(diag(-32768, 32767, -32768));
    pending_dcms.push_back(diag(-20000, -20000, -20000));
    pending_dcms.push_back('1);
    m = {9{16'sh7FFF}};
    pending_dcms.push_back(m);
    m = {9{16'sh8000}};
    pending_dcms.push_back(m);
    m = diag(0, 0, 16384);
    m.e12 = -16384; m.e21 = 16384;
    pending_dcms.push_back(m);
    m = diag(-32768, -32768, -32768);
    m.e12 = 32767; m.e21 = 32767; m.e13 = -32768; m.e31 = -32768;
    m.e23 = -32768; m.e32 = 32767;
    pending_dcms.push_back(m);
    m = diag(-16384, -16384, -16384);
    m.e32 = 32767; m.e23 = -32768; m.e13 = 32767; m.e31 = -32768;
    pending_dcms.push_back(m);
    for (int i = 0; i < 1050; i++) begin
      if ($urandom_range(0, 99) < 70) pending_dcms.push_back(rand_rotation());
      else begin
        m = {rand_elem(), rand_elem(), rand_elem(), rand_elem(), rand_elem(),
             rand_elem(), rand_elem(), rand_elem(), rand_elem()};
        pending_dcms.push_back(m);
      end
    end
    stim_done = 1;
  end

  // driver
  initial begin
    in_valid = 0;
    {m11, m12, m13, m21, m22, m23, m31, m32, m33} = '0;
  end

  always @(posedge clk) begin
    dcm_t m;
    if (!rst) begin
      if (!in_valid || !in_stall) begin
        if (in_valid) expected_quats.push_back(dcm_to_quat(
            {m11, m12, m13, m21, m22, m23, m31, m32, m33}));
        if (pending_dcms.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          m = pending_dcms.pop_front();
          in_valid <= 1;
          {m11, m12, m13, m21, m22, m23, m31, m32, m33} <= m;
        end else begin
          in_valid <= 0;
        end
      end
    end
  end

  // receiver stall, with one long hold-off
  initial out_stall = 1;

  always @(posedge clk) begin
    if (rst) out_stall <= 1;
    else if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_stall <= 1;
    end else out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
  end

  // monitor
  always @(posedge clk) begin
    quat_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_quats.size() == 0) begin
        report_mismatch("unexpected item", 1, 0);
      end else begin
        want = expected_quats.pop_front();
        if (qw !== want.w) report_mismatch("qw", qw, want.w);
        if (qx !== want.x) report_mismatch("qx", qx, want.x);
        if (qy !== want.y) report_mismatch("qy", qy, want.y);
        if (qz !== want.z) report_mismatch("qz", qz, want.z);
        if (pivot !== want.piv) report_mismatch("pivot", pivot, want.piv);
        if (degenerate !== want.degen) report_mismatch("degenerate", degenerate, want.degen);
      end
    end
  end

  // phases of idling and the end of the run
  initial begin
    wait (stim_done);
    wait (pending_dcms.size() < 700);
    send_idle_pct = 82;
    recv_idle_pct = 19;
    wait (pending_dcms.size() < 450);
    @(posedge clk);
    hold_cycles <= 4 * LATENCY;
    send_idle_pct = 0;
    wait (pending_dcms.size() < 300);
    recv_idle_pct = 0;
    wait (pending_dcms.size() == 0);
    @(posedge clk);
    while (in_valid || expected_quats.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    if (errors == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

  initial begin
    #2000000;
    $display("FAILURE");
    $finish;
  end
endmodule
